/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the space point projection block.
// The assertions are clocked by clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define SPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define SPP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/spp_pkg.sv */
// Package of the space point projection block: word types, pipeline stage
// numbers and the fixed-point rounding and saturation functions.
// Used by the interfaces, the arithmetic units and the top level.
package spp_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned EXT_BITS  = WORD_BITS + 4;
  localparam int unsigned PROD_BITS = 2 * WORD_BITS;
  localparam int unsigned QUO_BITS  = WORD_BITS + FRAC_BITS;

  // Unit latencies in cycles.
  localparam int unsigned LAT_DOT = 2;
  localparam int unsigned LAT_DIV = QUO_BITS + 2;

  // Pipeline stages at which unit results are merged back.
  localparam int unsigned ST_D    = 1;
  localparam int unsigned ST_COF  = ST_D + LAT_DOT + 1;
  localparam int unsigned ST_DET  = ST_COF + LAT_DOT + 1;
  localparam int unsigned ST_INV  = ST_DET + LAT_DIV + 1;
  localparam int unsigned ST_W    = ST_INV + LAT_DOT + 1;
  localparam int unsigned ST_C    = ST_W + LAT_DOT + 1;
  localparam int unsigned ST_DET2 = ST_C + LAT_DOT + 1;
  localparam int unsigned ST_OUT  = ST_DET2 + LAT_DIV + 1;

  // Configuration space.
  localparam int unsigned PADDR_BITS   = 3;
  localparam int unsigned PDATA_BITS   = 32;
  localparam logic        REG_CUT_MODE = 1'b0;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [EXT_BITS-1:0]  ext_t;
  typedef word_t [2:0]                 word3_t;
  typedef word_t [5:0]                 word6_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } sword_t;

  localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

  // Clips a widened sum to the word.
  function automatic sword_t sat_word(ext_t x);
    sword_t res;
    res.sat = 1'b0;
    res.val = word_t'(x);
    if (x > ext_t'(WORD_MAX)) begin
      res.sat = 1'b1;
      res.val = WORD_MAX;
    end else if (x < ext_t'(WORD_MIN)) begin
      res.sat = 1'b1;
      res.val = WORD_MIN;
    end
    return res;
  endfunction

  // Rounds an exact product to FRAC_BITS, half away from zero, and clips it.
  function automatic sword_t round_prod(prod_t p);
    logic                 neg;
    logic [PROD_BITS:0]   m;
    logic [PROD_BITS:0]   r;
    logic [PROD_BITS:0]   lim;
    sword_t               res;
    neg = p[PROD_BITS-1];
    m   = {1'b0, (neg ? -p : p)};
    r   = (m + ((PROD_BITS+1)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
    lim = ((PROD_BITS+1)'(1) << (WORD_BITS-1)) - (PROD_BITS+1)'(!neg);
    res.sat = 1'b0;
    if (r > lim) begin
      res.sat = 1'b1;
      r = lim;
    end
    res.val = neg ? -word_t'(r[WORD_BITS-1:0]) : word_t'(r[WORD_BITS-1:0]);
    return res;
  endfunction

endpackage

/* src/spp_if.sv */
// Valid/ready channel interfaces for items (hits and plane loads) in and projections out.
// Depends on spp_pkg for the word type.
interface spp_in_if;
  logic          valid;
  logic          ready;
  logic          mode;
  spp_pkg::word_t pos_x;
  spp_pkg::word_t pos_y;
  spp_pkg::word_t pos_z;
  spp_pkg::word_t first_x;
  spp_pkg::word_t first_y;
  spp_pkg::word_t first_z;
  spp_pkg::word_t second_x;
  spp_pkg::word_t second_y;
  spp_pkg::word_t second_z;

  modport source (output valid, mode, pos_x, pos_y, pos_z, first_x, first_y, first_z,
                  second_x, second_y, second_z, input ready);
  modport sink (input valid, mode, pos_x, pos_y, pos_z, first_x, first_y, first_z,
                second_x, second_y, second_z, output ready);
endinterface

interface spp_out_if;
  logic          valid;
  logic          ready;
  spp_pkg::word_t meas_u;
  spp_pkg::word_t meas_v;
  spp_pkg::word_t cov_uu;
  spp_pkg::word_t cov_uv;
  spp_pkg::word_t cov_vv;
  logic          singular;
  logic          saturated;

  modport source (output valid, meas_u, meas_v, cov_uu, cov_uv, cov_vv, singular,
                  saturated, input ready);
  modport sink (input valid, meas_u, meas_v, cov_uu, cov_uv, cov_vv, singular,
                saturated, output ready);
endinterface

/* src/spp_dot3.sv */
// Three-term fixed-point dot product with per-term subtraction, two stages.
// Depends on spp_pkg for the word types and rounding functions.
module spp_dot3 (
  input  logic            clk_i,
  input  logic            en_i,
  input  spp_pkg::word3_t a_i,
  input  spp_pkg::word3_t b_i,
  input  logic [2:0]      sub_i,
  output spp_pkg::sword_t res_o
);

  spp_pkg::prod_t  prod_q [3];
  logic [2:0]      sub_q;
  spp_pkg::sword_t res_d;

  // First stage: exact products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= spp_pkg::prod_t'(spp_pkg::word_t'(a_i[k]))
                   * spp_pkg::prod_t'(spp_pkg::word_t'(b_i[k]));
      end
      sub_q <= sub_i;
    end
  end

  // Second stage: round each product, add them up and clip the sum.
  always_comb begin
    spp_pkg::sword_t r;
    spp_pkg::ext_t   sum;
    logic            sat;
    sum = '0;
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      r   = spp_pkg::round_prod(prod_q[k]);
      sat = sat | r.sat;
      if (sub_q[k]) begin
        sum = sum - spp_pkg::ext_t'(r.val);
      end else begin
        sum = sum + spp_pkg::ext_t'(r.val);
      end
    end
    res_d     = spp_pkg::sat_word(sum);
    res_d.sat = res_d.sat | sat;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

endmodule

/* src/spp_div.sv */
// Pipelined fixed-point divider: one quotient bit per stage, rounded to
// nearest and clipped at the end. Depends on spp_pkg.
module spp_div (
  input  logic            clk_i,
  input  logic            en_i,
  input  spp_pkg::word_t  num_i,
  input  spp_pkg::word_t  den_i,
  output spp_pkg::sword_t res_o
);

  localparam int unsigned WB = spp_pkg::WORD_BITS;
  localparam int unsigned QB = spp_pkg::QUO_BITS;

  typedef struct packed {
    logic          neg;
    logic [WB-1:0] den;
    logic [QB-1:0] num;
    logic [WB-1:0] rem;
    logic [QB-1:0] quo;
  } div_st_t;

  div_st_t st_q [QB+1];
  div_st_t st_d [QB+1];
  spp_pkg::sword_t res_d;

  // Operand magnitudes; the dividend is scaled by the fraction bits.
  always_comb begin
    logic [WB-1:0] na;
    na = num_i[WB-1] ? WB'(-num_i) : WB'(num_i);
    st_d[0].neg = num_i[WB-1] ^ den_i[WB-1];
    st_d[0].den = den_i[WB-1] ? WB'(-den_i) : WB'(den_i);
    st_d[0].num = {na, {spp_pkg::FRAC_BITS{1'b0}}};
    st_d[0].rem = '0;
    st_d[0].quo = '0;
  end

  // Restoring division steps.
  always_comb begin
    logic [WB:0] trial;
    logic        ge;
    for (int i = 1; i <= QB; i++) begin
      trial         = {st_q[i-1].rem, st_q[i-1].num[QB-1]};
      ge            = trial >= {1'b0, st_q[i-1].den};
      st_d[i]       = st_q[i-1];
      st_d[i].rem   = ge ? WB'(trial - {1'b0, st_q[i-1].den}) : WB'(trial);
      st_d[i].num   = {st_q[i-1].num[QB-2:0], 1'b0};
      st_d[i].quo   = {st_q[i-1].quo[QB-2:0], ge};
    end
  end

  // Round to nearest from the remainder, then clip to the word.
  always_comb begin
    logic        up;
    logic [QB:0] q1;
    logic [QB:0] lim;
    up  = {st_q[QB].rem, 1'b0} >= {1'b0, st_q[QB].den};
    q1  = {1'b0, st_q[QB].quo} + (QB+1)'(up);
    lim = ((QB+1)'(1) << (WB-1)) - (QB+1)'(!st_q[QB].neg);
    res_d.sat = 1'b0;
    if (q1 > lim) begin
      res_d.sat = 1'b1;
      q1 = lim;
    end
    res_d.val = st_q[QB].neg ? -spp_pkg::word_t'(q1[WB-1:0])
                             : spp_pkg::word_t'(q1[WB-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q  <= st_d;
      res_o <= res_d;
    end
  end

endmodule

/* src/spacepoint_plane_projection_top.sv */
// Top level of the space point projection block: channels, plane state,
// configuration register and the projection pipeline.
// Depends on spp_pkg, spp_if, spp_dot3 and spp_div.
//
// Usage:
// - in_i takes items. A mode 0 item loads the plane origin, u and v and gives
//   no result. A mode 1 item is a hit and gives exactly one result on out_o.
// - The APB port holds cut_mode at byte address 0 (reset 1). Write it only
//   while the block is idle.
// - The two 48-step dividers (inverse and reinverse) account for most of the
//   pipeline depth.
// - Throughput: one item per cycle while out_o is not stalled; every stage is a
//   register stage that advances together.
// - When out_o is stalled the whole pipeline holds. A one-entry skid register
//   at the input still takes one more transaction; in_i.ready drops only
//   while that entry is full.
// - Reset clears the plane to zero, sets cut_mode and empties the pipeline.
`include "assert_macros.svh"

module spacepoint_plane_projection_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [spp_pkg::PADDR_BITS-1:0] paddr,
  input  logic [spp_pkg::PDATA_BITS-1:0] pwdata,
  output logic [spp_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready,
  spp_in_if.sink                         in_i,
  spp_out_if.source                      out_o
);

  localparam int unsigned NS = spp_pkg::ST_OUT + 1;

  // Dot unit numbering.
  localparam int unsigned D_MU = 0, D_MV = 1, D_COF = 2, D_DET = 8, D_WU = 9,
                          D_WV = 12, D_C = 15, D_DET2 = 18, NUM_DOT = 19;
  // Divider numbering.
  localparam int unsigned V_INV = 0, V_RE = 6, NUM_DIV = 9;

  typedef struct packed {
    logic            mode;
    spp_pkg::word3_t pos;
    spp_pkg::word3_t first;
    spp_pkg::word3_t second;
  } item_t;

  typedef struct packed {
    spp_pkg::word3_t org;
    spp_pkg::word3_t u;
    spp_pkg::word3_t v;
    spp_pkg::word3_t p;
    spp_pkg::word6_t m;
    spp_pkg::word6_t cof;
    spp_pkg::word_t  det;
    spp_pkg::word3_t wu;
    spp_pkg::word3_t wv;
    spp_pkg::word3_t cc;
    spp_pkg::word_t  nc1;
    spp_pkg::word_t  det2;
    spp_pkg::word_t  meas_u;
    spp_pkg::word_t  meas_v;
    logic            sat;
    logic            sat_c;
    logic            sing;
  } pipe_t;

  logic            cut_mode_q;
  spp_pkg::word3_t org_q, u_q, v_q;
  item_t           in_item, skid_q, ent;
  logic            skid_valid_q, in_acc, en;
  logic [NS-1:0]   valid_q, valid_d;
  pipe_t           pipe_q [NS];
  pipe_t           pipe_d [NS];

  spp_pkg::word3_t dot_a [NUM_DOT];
  spp_pkg::word3_t dot_b [NUM_DOT];
  logic [2:0]      dot_sub [NUM_DOT];
  spp_pkg::sword_t dot_res [NUM_DOT];
  spp_pkg::word_t  div_num [NUM_DIV];
  spp_pkg::word_t  div_den [NUM_DIV];
  spp_pkg::sword_t div_res [NUM_DIV];

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == spp_pkg::REG_CUT_MODE)
                ? {{(spp_pkg::PDATA_BITS-1){1'b0}}, cut_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_mode_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == spp_pkg::REG_CUT_MODE) begin
      cut_mode_q <= pwdata[0];
    end
  end

  // Input transaction, skid entry and pipeline enable.
  assign en         = !valid_q[NS-1] || out_o.ready;
  assign in_i.ready = !skid_valid_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_item    = '{mode: in_i.mode,
                        pos: {in_i.pos_z, in_i.pos_y, in_i.pos_x},
                        first: {in_i.first_z, in_i.first_y, in_i.first_x},
                        second: {in_i.second_z, in_i.second_y, in_i.second_x}};
  assign ent        = skid_valid_q ? skid_q : in_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (en) begin
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !en) begin
      skid_q <= in_item;
    end
  end

  // Plane state, loaded by a mode 0 transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q <= '0;
      u_q   <= '0;
      v_q   <= '0;
    end else if (in_acc && !in_i.mode) begin
      org_q <= in_item.pos;
      u_q   <= in_item.first;
      v_q   <= in_item.second;
    end
  end

  // Valid bits; a load leaves a bubble behind.
  always_comb begin
    valid_d    = {valid_q[NS-2:0], 1'b0};
    valid_d[0] = skid_valid_q ? skid_q.mode : (in_acc && in_i.mode);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  // Unit operands taken from their source stages.
  always_comb begin
    for (int i = 0; i < NUM_DOT; i++) begin
      dot_a[i]   = '0;
      dot_b[i]   = '0;
      dot_sub[i] = 3'b000;
    end
    // Offsets along u and v.
    dot_a[D_MU] = pipe_q[spp_pkg::ST_D].p;
    dot_b[D_MU] = pipe_q[spp_pkg::ST_D].u;
    dot_a[D_MV] = pipe_q[spp_pkg::ST_D].p;
    dot_b[D_MV] = pipe_q[spp_pkg::ST_D].v;
    // Cofactors, each a difference of two products.
    for (int k = 0; k < 6; k++) begin
      dot_sub[D_COF+k] = 3'b010;
    end
    dot_a[D_COF+0][0] = pipe_q[spp_pkg::ST_D].m[1];
    dot_b[D_COF+0][0] = pipe_q[spp_pkg::ST_D].m[2];
    dot_a[D_COF+0][1] = pipe_q[spp_pkg::ST_D].m[5];
    dot_b[D_COF+0][1] = pipe_q[spp_pkg::ST_D].m[5];
    dot_a[D_COF+1][0] = pipe_q[spp_pkg::ST_D].m[0];
    dot_b[D_COF+1][0] = pipe_q[spp_pkg::ST_D].m[2];
    dot_a[D_COF+1][1] = pipe_q[spp_pkg::ST_D].m[4];
    dot_b[D_COF+1][1] = pipe_q[spp_pkg::ST_D].m[4];
    dot_a[D_COF+2][0] = pipe_q[spp_pkg::ST_D].m[0];
    dot_b[D_COF+2][0] = pipe_q[spp_pkg::ST_D].m[1];
    dot_a[D_COF+2][1] = pipe_q[spp_pkg::ST_D].m[3];
    dot_b[D_COF+2][1] = pipe_q[spp_pkg::ST_D].m[3];
    dot_a[D_COF+3][0] = pipe_q[spp_pkg::ST_D].m[4];
    dot_b[D_COF+3][0] = pipe_q[spp_pkg::ST_D].m[5];
    dot_a[D_COF+3][1] = pipe_q[spp_pkg::ST_D].m[3];
    dot_b[D_COF+3][1] = pipe_q[spp_pkg::ST_D].m[2];
    dot_a[D_COF+4][0] = pipe_q[spp_pkg::ST_D].m[3];
    dot_b[D_COF+4][0] = pipe_q[spp_pkg::ST_D].m[5];
    dot_a[D_COF+4][1] = pipe_q[spp_pkg::ST_D].m[4];
    dot_b[D_COF+4][1] = pipe_q[spp_pkg::ST_D].m[1];
    dot_a[D_COF+5][0] = pipe_q[spp_pkg::ST_D].m[3];
    dot_b[D_COF+5][0] = pipe_q[spp_pkg::ST_D].m[4];
    dot_a[D_COF+5][1] = pipe_q[spp_pkg::ST_D].m[0];
    dot_b[D_COF+5][1] = pipe_q[spp_pkg::ST_D].m[5];
    // Determinant along the first row.
    dot_a[D_DET] = {pipe_q[spp_pkg::ST_COF].m[4], pipe_q[spp_pkg::ST_COF].m[3],
                    pipe_q[spp_pkg::ST_COF].m[0]};
    dot_b[D_DET] = {pipe_q[spp_pkg::ST_COF].cof[4], pipe_q[spp_pkg::ST_COF].cof[3],
                    pipe_q[spp_pkg::ST_COF].cof[0]};
    // Matrix times u and times v, row by row.
    for (int r = 0; r < 3; r++) begin
      dot_b[D_WU+r] = pipe_q[spp_pkg::ST_INV].u;
      dot_b[D_WV+r] = pipe_q[spp_pkg::ST_INV].v;
    end
    dot_a[D_WU+0] = {pipe_q[spp_pkg::ST_INV].m[4], pipe_q[spp_pkg::ST_INV].m[3],
                     pipe_q[spp_pkg::ST_INV].m[0]};
    dot_a[D_WU+1] = {pipe_q[spp_pkg::ST_INV].m[5], pipe_q[spp_pkg::ST_INV].m[1],
                     pipe_q[spp_pkg::ST_INV].m[3]};
    dot_a[D_WU+2] = {pipe_q[spp_pkg::ST_INV].m[2], pipe_q[spp_pkg::ST_INV].m[5],
                     pipe_q[spp_pkg::ST_INV].m[4]};
    for (int r = 0; r < 3; r++) begin
      dot_a[D_WV+r] = dot_a[D_WU+r];
    end
    // Projected covariance before reinversion.
    dot_a[D_C+0] = pipe_q[spp_pkg::ST_W].u;
    dot_b[D_C+0] = pipe_q[spp_pkg::ST_W].wu;
    dot_a[D_C+1] = pipe_q[spp_pkg::ST_W].v;
    dot_b[D_C+1] = pipe_q[spp_pkg::ST_W].wu;
    dot_a[D_C+2] = pipe_q[spp_pkg::ST_W].v;
    dot_b[D_C+2] = pipe_q[spp_pkg::ST_W].wv;
    // 2x2 determinant uu*vv - uv*uv.
    dot_sub[D_DET2]  = 3'b010;
    dot_a[D_DET2][0] = pipe_q[spp_pkg::ST_C].cc[0];
    dot_b[D_DET2][0] = pipe_q[spp_pkg::ST_C].cc[2];
    dot_a[D_DET2][1] = pipe_q[spp_pkg::ST_C].cc[1];
    dot_b[D_DET2][1] = pipe_q[spp_pkg::ST_C].cc[1];
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      div_num[V_INV+k] = pipe_q[spp_pkg::ST_DET].cof[k];
      div_den[V_INV+k] = pipe_q[spp_pkg::ST_DET].det;
    end
    div_num[V_RE+0] = pipe_q[spp_pkg::ST_DET2].cc[2];
    div_num[V_RE+1] = pipe_q[spp_pkg::ST_DET2].nc1;
    div_num[V_RE+2] = pipe_q[spp_pkg::ST_DET2].cc[0];
    for (int k = 0; k < 3; k++) begin
      div_den[V_RE+k] = pipe_q[spp_pkg::ST_DET2].det2;
    end
  end

  for (genvar g = 0; g < NUM_DOT; g++) begin : g_dot
    spp_dot3 u_dot (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (dot_a[g]),
      .b_i   (dot_b[g]),
      .sub_i (dot_sub[g]),
      .res_o (dot_res[g])
    );
  end

  for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
    spp_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (div_num[g]),
      .den_i (div_den[g]),
      .res_o (div_res[g])
    );
  end

  // Pipeline stages: each but the entry stage copies its predecessor, and the
  // merge stages fold unit results back in.
  always_comb begin
    logic            dz;
    logic            dsat;
    spp_pkg::sword_t cl;
    pipe_t           s;

    // Entry stage takes the item together with the plane it sees.
    pipe_d[0]        = '0;
    pipe_d[0].org    = org_q;
    pipe_d[0].u      = u_q;
    pipe_d[0].v      = v_q;
    pipe_d[0].p      = ent.pos;
    pipe_d[0].m      = {ent.second, ent.first};
    for (int k = 1; k < NS; k++) begin
      pipe_d[k] = pipe_q[k-1];
    end

    // Hit offset from the origin.
    s = pipe_q[spp_pkg::ST_D-1];
    for (int k = 0; k < 3; k++) begin
      cl = spp_pkg::sat_word(spp_pkg::ext_t'(spp_pkg::word_t'(s.p[k]))
                           - spp_pkg::ext_t'(spp_pkg::word_t'(s.org[k])));
      s.p[k] = cl.val;
      s.sat  = s.sat | cl.sat;
    end
    pipe_d[spp_pkg::ST_D] = s;

    // Offsets and cofactors.
    s        = pipe_q[spp_pkg::ST_COF-1];
    s.meas_u = dot_res[D_MU].val;
    s.meas_v = dot_res[D_MV].val;
    s.sat    = s.sat | dot_res[D_MU].sat | dot_res[D_MV].sat;
    for (int k = 0; k < 6; k++) begin
      s.cof[k] = dot_res[D_COF+k].val;
      s.sat_c  = s.sat_c | dot_res[D_COF+k].sat;
    end
    pipe_d[spp_pkg::ST_COF] = s;

    // 3x3 determinant.
    s       = pipe_q[spp_pkg::ST_DET-1];
    s.det   = dot_res[D_DET].val;
    s.sat_c = s.sat_c | dot_res[D_DET].sat;
    pipe_d[spp_pkg::ST_DET] = s;

    // Inverse, or the matrix as given in projection mode.
    s    = pipe_q[spp_pkg::ST_INV-1];
    dz   = (s.det == '0);
    dsat = 1'b0;
    for (int k = 0; k < 6; k++) begin
      dsat = dsat | div_res[V_INV+k].sat;
      if (cut_mode_q) begin
        s.m[k] = dz ? '0 : div_res[V_INV+k].val;
      end
    end
    s.sat_c = s.sat_c | (!dz && dsat);
    s.sing  = s.sing | (cut_mode_q && dz);
    pipe_d[spp_pkg::ST_INV] = s;

    // Matrix times u and v.
    s = pipe_q[spp_pkg::ST_W-1];
    for (int r = 0; r < 3; r++) begin
      s.wu[r] = dot_res[D_WU+r].val;
      s.wv[r] = dot_res[D_WV+r].val;
      s.sat   = s.sat | dot_res[D_WU+r].sat | dot_res[D_WV+r].sat;
    end
    pipe_d[spp_pkg::ST_W] = s;

    // Projected 2x2 covariance.
    s = pipe_q[spp_pkg::ST_C-1];
    for (int k = 0; k < 3; k++) begin
      s.cc[k] = dot_res[D_C+k].val;
      s.sat   = s.sat | dot_res[D_C+k].sat;
    end
    pipe_d[spp_pkg::ST_C] = s;

    // 2x2 determinant and the negated off-diagonal term.
    s       = pipe_q[spp_pkg::ST_DET2-1];
    s.det2  = dot_res[D_DET2].val;
    s.sat_c = s.sat_c | dot_res[D_DET2].sat;
    cl      = spp_pkg::sat_word(-spp_pkg::ext_t'(spp_pkg::word_t'(s.cc[1])));
    s.nc1   = cl.val;
    s.sat_c = s.sat_c | (cl.sat && s.det2 != '0);
    pipe_d[spp_pkg::ST_DET2] = s;

    // Reinversion and the final flags.
    s    = pipe_q[spp_pkg::ST_OUT-1];
    dz   = (s.det2 == '0);
    dsat = div_res[V_RE+0].sat | div_res[V_RE+1].sat | div_res[V_RE+2].sat;
    if (cut_mode_q) begin
      for (int k = 0; k < 3; k++) begin
        s.cc[k] = dz ? '0 : div_res[V_RE+k].val;
      end
      s.sing  = s.sing | dz;
      s.sat_c = s.sat_c | (!dz && dsat);
    end
    s.sat = s.sat | (cut_mode_q && s.sat_c);
    pipe_d[spp_pkg::ST_OUT] = s;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q <= pipe_d;
    end
  end

  // Result transaction.
  assign out_o.valid     = valid_q[NS-1];
  assign out_o.meas_u    = pipe_q[NS-1].meas_u;
  assign out_o.meas_v    = pipe_q[NS-1].meas_v;
  assign out_o.cov_uu    = pipe_q[NS-1].cc[0];
  assign out_o.cov_uv    = pipe_q[NS-1].cc[1];
  assign out_o.cov_vv    = pipe_q[NS-1].cc[2];
  assign out_o.singular  = pipe_q[NS-1].sing;
  assign out_o.saturated = pipe_q[NS-1].sat;

  // The skid entry drains whenever the pipeline moves.
  `SPP_ASSERT(a_skid_drain, en |=> !skid_valid_q, "skid entry not drained on advance")
  // Valid bits shift by one stage on every advance.
  `SPP_ASSERT(a_valid_shift, en |=> valid_q[NS-1] == $past(valid_q[NS-2]),
              "valid bit lost or repeated in the pipeline")
  // Projection mode never reports a singular matrix.
  `SPP_ASSERT_IMPL(a_no_sing, valid_q[NS-1] && !cut_mode_q, !pipe_q[NS-1].sing,
                   "singular flag in projection mode")
  // A singular reinversion leaves a zero covariance.
  `SPP_ASSERT_IMPL(a_sing_zero, valid_q[NS-1] && cut_mode_q && pipe_q[NS-1].det2 == '0,
                   pipe_q[NS-1].sing && pipe_q[NS-1].cc == '0,
                   "nonzero covariance from a singular 2x2 matrix")

endmodule
